// ===== sv/pcm_window_level_db_top_defines.svh =====
// pcm_window_level_db_top_defines.svh: assertion macros for the level meter checker
// expects signals named clk and rst in the scope of use
`ifndef PCM_WINDOW_LEVEL_DB_TOP_DEFINES_SVH
`define PCM_WINDOW_LEVEL_DB_TOP_DEFINES_SVH

// same-cycle implication
`define PCM_LVL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCM_LVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcm_lvl_pkg.sv =====
// pcm_lvl_pkg.sv: types, widths, codes and the dB threshold table of the level meter
// no dependencies
package pcm_lvl_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int FMT_W       = 2;
  localparam int WINLEN_W    = 17;
  localparam int LEVEL_W     = 7;
  localparam int WIN_NUM_W   = 16;
  localparam int MAG_W       = 16;
  localparam int MEAN_W      = 16;
  localparam int MAX_WINDOW  = 65536;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = MAG_W + CNT_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = WINLEN_W;
  localparam int LEVEL_MAX   = 96;
  localparam int FULL_SCALE  = 65535;
  localparam int WINLEN_RESET = 8820;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int DIV_STEP_W  = $clog2(SUM_W);

  typedef enum logic [FMT_W-1:0] {
    FMT_S16 = 2'd0,
    FMT_S24 = 2'd1,
    FMT_S32 = 2'd2,
    FMT_F32 = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT = 1'b0,
    CFG_WINDOW = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [CNT_W-1:0]     count;
    logic [WIN_NUM_W-1:0] number;
  } win_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // smallest mean m with m^20 >= 10^k, k = 0..96
  localparam logic [MEAN_W-1:0] LEVEL_THRESH [0:LEVEL_MAX] = '{
    16'd1,     16'd2,     16'd2,     16'd2,     16'd2,
    16'd2,     16'd2,     16'd3,     16'd3,     16'd3,
    16'd4,     16'd4,     16'd4,     16'd5,     16'd6,
    16'd6,     16'd7,     16'd8,     16'd8,     16'd9,
    16'd10,    16'd12,    16'd13,    16'd15,    16'd16,
    16'd18,    16'd20,    16'd23,    16'd26,    16'd29,
    16'd32,    16'd36,    16'd40,    16'd45,    16'd51,
    16'd57,    16'd64,    16'd71,    16'd80,    16'd90,
    16'd100,   16'd113,   16'd126,   16'd142,   16'd159,
    16'd178,   16'd200,   16'd224,   16'd252,   16'd282,
    16'd317,   16'd355,   16'd399,   16'd447,   16'd502,
    16'd563,   16'd631,   16'd708,   16'd795,   16'd892,
    16'd1000,  16'd1123,  16'd1259,  16'd1413,  16'd1585,
    16'd1779,  16'd1996,  16'd2239,  16'd2512,  16'd2819,
    16'd3163,  16'd3549,  16'd3982,  16'd4467,  16'd5012,
    16'd5624,  16'd6310,  16'd7080,  16'd7944,  16'd8913,
    16'd10000, 16'd11221, 16'd12590, 16'd14126, 16'd15849,
    16'd17783, 16'd19953, 16'd22388, 16'd25119, 16'd28184,
    16'd31623, 16'd35482, 16'd39811, 16'd44669, 16'd50119,
    16'd56235, 16'd63096
  };

endpackage

// ===== sv/pcm_lvl_ifs.sv =====
// pcm_lvl_ifs.sv: valid/ready channel interfaces for samples, levels and register writes
// depends on pcm_lvl_pkg
interface pcm_lvl_sample_if import pcm_lvl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_bits;
  modport source (output valid, output sample_bits, input ready);
  modport sink (input valid, input sample_bits, output ready);
endinterface

interface pcm_lvl_level_if import pcm_lvl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LEVEL_W-1:0]   level_db;
  logic [WIN_NUM_W-1:0] window_number;
  modport source (output valid, output level_db, output window_number, input ready);
  modport sink (input valid, input level_db, input window_number, output ready);
endinterface

interface pcm_lvl_cfg_if import pcm_lvl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/pcm_lvl_front.sv =====
// pcm_lvl_front.sv: register file, sample normalization and window accumulation
// depends on pcm_lvl_pkg and pcm_lvl_ifs
module pcm_lvl_front import pcm_lvl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  pcm_lvl_cfg_if.sink       cfg,
  pcm_lvl_sample_if.sink    samples,
  input  q_stat_t           q_stat,
  output logic              push,
  output win_entry_t        push_entry
);

  fmt_t                 sample_format;
  logic [WINLEN_W-1:0]  window_samples;
  logic [SUM_W-1:0]     magnitude_sum;
  logic [CNT_W-1:0]     samples_in_window;
  logic [WIN_NUM_W-1:0] window_counter;

  logic [MAG_W-1:0]     mag;
  logic [CNT_W-1:0]     win_len;
  logic [CNT_W-1:0]     count_next;
  logic [SUM_W-1:0]     sum_next;
  logic                 fire;
  logic                 close;

  always_comb begin
    logic [15:0] v16;
    logic [23:0] v24;
    logic [31:0] v32;
    logic [7:0]  fexp;
    logic [7:0]  fexp_eff;
    logic [23:0] fman;
    logic [7:0]  fshift;
    logic [39:0] fprod;
    logic [39:0] fscaled;
    v16 = samples.sample_bits[15:0];
    v24 = samples.sample_bits[23:0];
    v32 = samples.sample_bits;
    fexp = samples.sample_bits[30:23];
    fexp_eff = (fexp == 8'd0) ? 8'd1 : fexp;
    fman = {(fexp != 8'd0), samples.sample_bits[22:0]};
    fshift = 8'd150 - fexp_eff;
    fprod = {fman, 16'd0} - {16'd0, fman};
    fscaled = fprod >> fshift;
    case (sample_format)
      FMT_S16: begin
        mag = v16[15] ? (~v16 + 16'd1) : v16;
      end
      FMT_S24: begin
        v24 = v24[23] ? (~v24 + 24'd1) : v24;
        mag = v24[23:8];
      end
      FMT_S32: begin
        v32 = v32[31] ? (~v32 + 32'd1) : v32;
        mag = v32[31:16];
      end
      FMT_F32: begin
        if (fexp >= 8'd127) begin
          mag = MAG_W'(FULL_SCALE);
        end else if (fshift >= 8'd40) begin
          mag = '0;
        end else begin
          mag = fscaled[MAG_W-1:0];
        end
      end
      default: begin
        mag = '0;
      end
    endcase
  end

  always_comb begin
    if (window_samples == '0) begin
      win_len = CNT_W'(1);
    end else if (32'(window_samples) > 32'(MAX_WINDOW)) begin
      win_len = CNT_W'(MAX_WINDOW);
    end else begin
      win_len = CNT_W'(window_samples);
    end
  end

  assign count_next = samples_in_window + CNT_W'(1);
  assign sum_next   = magnitude_sum + SUM_W'(mag);
  assign close      = (count_next >= win_len);

  assign samples.ready = !q_stat.full;
  assign cfg.ready     = 1'b1;
  assign fire          = samples.valid && samples.ready;

  assign push              = fire && close;
  assign push_entry.sum    = sum_next;
  assign push_entry.count  = count_next;
  assign push_entry.number = window_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format     <= FMT_S16;
      window_samples    <= WINLEN_W'(WINLEN_RESET);
      magnitude_sum     <= '0;
      samples_in_window <= '0;
      window_counter    <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_FORMAT: sample_format  <= fmt_t'(cfg.data[FMT_W-1:0]);
          CFG_WINDOW: window_samples <= cfg.data[WINLEN_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        if (close) begin
          magnitude_sum     <= '0;
          samples_in_window <= '0;
          window_counter    <= window_counter + WIN_NUM_W'(1);
        end else begin
          magnitude_sum     <= sum_next;
          samples_in_window <= count_next;
        end
      end
    end
  end

endmodule

// ===== sv/pcm_lvl_fifo.sv =====
// pcm_lvl_fifo.sv: short queue of finished window sums between front and back
// depends on pcm_lvl_pkg
module pcm_lvl_fifo import pcm_lvl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  win_entry_t push_entry,
  input  logic       pop,
  output win_entry_t pop_entry,
  output q_stat_t    q_stat
);

  win_entry_t         entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign pop_entry    = entries[rd_ptr];
  assign q_stat.full  = (fill == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/pcm_lvl_back.sv =====
// pcm_lvl_back.sv: mean by restoring division, dB by binary search, output register
// depends on pcm_lvl_pkg and pcm_lvl_ifs
module pcm_lvl_back import pcm_lvl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  q_stat_t         q_stat,
  input  win_entry_t      pop_entry,
  output logic            pop,
  pcm_lvl_level_if.source levels
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SEARCH,
    S_HOLD
  } state_t;

  state_t                state;
  logic [SUM_W-1:0]      div_num;
  logic [CNT_W-1:0]      div_rem;
  logic [CNT_W-1:0]      div_den;
  logic [DIV_STEP_W-1:0] div_step;
  logic [WIN_NUM_W-1:0]  number;
  logic [MEAN_W-1:0]     mean;
  logic [LEVEL_W-1:0]    lo;
  logic [LEVEL_W-1:0]    hi;
  logic                  out_valid;
  logic [LEVEL_W-1:0]    out_level;
  logic [WIN_NUM_W-1:0]  out_number;

  logic [CNT_W:0]        rem_shift;
  logic                  sub_ok;
  logic [CNT_W-1:0]      rem_next;
  logic [SUM_W-1:0]      num_next;
  logic [MEAN_W-1:0]     mean_next;
  logic [LEVEL_W-1:0]    mid;
  logic                  out_free;

  assign rem_shift = {div_rem, div_num[SUM_W-1]};
  assign sub_ok    = (rem_shift >= {1'b0, div_den});
  assign rem_next  = sub_ok ? CNT_W'(rem_shift - {1'b0, div_den}) : CNT_W'(rem_shift);
  assign num_next  = {div_num[SUM_W-2:0], sub_ok};
  assign mean_next = (num_next > SUM_W'(FULL_SCALE)) ? MEAN_W'(FULL_SCALE)
                                                     : num_next[MEAN_W-1:0];
  assign mid       = LEVEL_W'(({1'b0, lo} + {1'b0, hi} + (LEVEL_W + 1)'(1)) >> 1);

  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign out_free = !out_valid || levels.ready;

  assign levels.valid         = out_valid;
  assign levels.level_db      = out_level;
  assign levels.window_number = out_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_step  <= '0;
      lo        <= '0;
      hi        <= '0;
    end else begin
      if (out_valid && levels.ready && state != S_HOLD) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            div_num  <= pop_entry.sum;
            div_den  <= pop_entry.count;
            div_rem  <= '0;
            number   <= pop_entry.number;
            div_step <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          div_num  <= num_next;
          div_rem  <= rem_next;
          div_step <= div_step + DIV_STEP_W'(1);
          if (div_step == DIV_STEP_W'(SUM_W - 1)) begin
            mean  <= mean_next;
            lo    <= '0;
            hi    <= LEVEL_W'(LEVEL_MAX);
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (lo == hi) begin
            state <= S_HOLD;
          end else if (LEVEL_THRESH[mid] <= mean) begin
            lo <= mid;
          end else begin
            hi <= mid - LEVEL_W'(1);
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_level  <= lo;
            out_number <= number;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/pcm_window_level_db_top.sv =====
// Window level meter: mean absolute sample magnitude over a window, reported in dB.
// Channels: samples (valid/ready, sample_bits), levels (valid/ready, level_db and
// window_number), cfg (valid/ready register writes: index 0 sample format,
// index 1 samples per window). cfg is always ready; write it only while idle.
// A sample transfers in every cycle while the two-entry window queue has room.
// The sample that fills a window pushes its sum and count to the queue; the back
// end then pops it and works on one window at a time (33-step restoring divider, up
// to 8 steps of threshold search, then a load of the output register) before it
// pops the next window. Windows that close faster than the back end can handle
// them throttle the sample channel through ready.
// A stalled levels receiver holds the output register; the back end finishes the
// next window and waits, and the queue then fills and deasserts samples.ready.
// Reset (rst, synchronous) clears the sum, count, window number, queue and
// output, and loads format 16-bit signed and a window of 8820 samples.
// Depends on pcm_lvl_pkg, pcm_lvl_ifs, pcm_lvl_front, pcm_lvl_fifo, pcm_lvl_back.
module pcm_window_level_db_top import pcm_lvl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  pcm_lvl_cfg_if.sink     cfg,
  pcm_lvl_sample_if.sink  samples,
  pcm_lvl_level_if.source levels
);

  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  win_entry_t push_entry;
  win_entry_t pop_entry;

  pcm_lvl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .samples    (samples),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  pcm_lvl_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  pcm_lvl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .levels    (levels)
  );

endmodule

// ===== sv/pcm_lvl_checker.sv =====
// pcm_lvl_checker.sv: port-level assertions for the level meter, bound to the top level
// depends on pcm_lvl_pkg and pcm_window_level_db_top_defines.svh
`include "pcm_window_level_db_top_defines.svh"

module pcm_lvl_checker import pcm_lvl_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [LEVEL_W-1:0]   level_db,
  input logic [WIN_NUM_W-1:0] window_number
);

  logic [WIN_NUM_W-1:0] exp_number;
  logic                 seen_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_number <= '0;
      seen_input <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        exp_number <= exp_number + WIN_NUM_W'(1);
      end
      if (in_valid && in_ready) begin
        seen_input <= 1'b1;
      end
    end
  end

  `PCM_LVL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(level_db) && $stable(window_number), "stalled level changed")
  `PCM_LVL_ASSERT_NOW(a_level_range, out_valid, level_db <= LEVEL_W'(LEVEL_MAX),
    "level above full scale")
  `PCM_LVL_ASSERT_NOW(a_number_seq, out_valid, window_number == exp_number,
    "window number out of sequence")
  `PCM_LVL_ASSERT_NOW(a_no_spurious, out_valid, seen_input,
    "level without any sample transfer")

endmodule

bind pcm_window_level_db_top pcm_lvl_checker u_pcm_lvl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (levels.valid),
  .out_ready     (levels.ready),
  .level_db      (levels.level_db),
  .window_number (levels.window_number)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top.sv: self-checking bench for the window level meter; predicts the dB level and number
// of every finished window from the accepted samples and checks each level transfer in order
// depends on pcm_lvl_pkg, pcm_lvl_ifs and pcm_window_level_db_top
module tb_top;
  import pcm_lvl_pkg::*;

  localparam int     RANDOM_ITEMS  = 1100;
  localparam int     SETTLE_CYCLES = 100;
  localparam int     HOLD_CYCLES   = 400;
  localparam longint TIMEOUT_NS    = 64'd100_000_000;

  typedef struct {
    logic [LEVEL_W-1:0]   db;
    logic [WIN_NUM_W-1:0] num;
  } level_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcm_lvl_cfg_if    cfg();
  pcm_lvl_sample_if samples();
  pcm_lvl_level_if  levels();

  pcm_window_level_db_top u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .levels  (levels)
  );

  logic [SAMPLE_W-1:0]  sample_pending[$];
  level_rec_t           pending_levels[$];
  fmt_t                 fmt_cfg = FMT_S16;
  logic [WINLEN_W-1:0]  win_len_cfg = WINLEN_W'(WINLEN_RESET);
  logic [63:0]          mag_sum = '0;
  int unsigned          win_fill = 0;
  logic [WIN_NUM_W-1:0] win_num = '0;
  int                   errors = 0;
  bit                   sample_taken = 1'b0;
  int                   send_gap = 0;
  int                   recv_gap = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   level_hold_req = 0;
  int                   level_hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 100) $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  function automatic logic [MAG_W-1:0] sample_magnitude(fmt_t f, logic [SAMPLE_W-1:0] x);
    logic [63:0] v;
    logic [63:0] m;
    int unsigned e;
    int unsigned sh;
    case (f)
      FMT_S16: begin
        v = {48'd0, x[15:0]};
        if (x[15]) v = 64'h1_0000 - v;
        return v[MAG_W-1:0];
      end
      FMT_S24: begin
        v = {40'd0, x[23:0]};
        if (x[23]) v = 64'h100_0000 - v;
        return v[23:8];
      end
      FMT_S32: begin
        v = {32'd0, x};
        if (x[31]) v = 64'h1_0000_0000 - v;
        return v[31:16];
      end
      default: begin
        e = x[30:23];
        m = {41'd0, x[22:0]};
        if (e >= 127) return MAG_W'(FULL_SCALE);
        if (e == 0) e = 1;
        else m[23] = 1'b1;
        sh = 150 - e;
        if (sh >= 64) return '0;
        v = (m * FULL_SCALE) >> sh;
        return (v > FULL_SCALE) ? MAG_W'(FULL_SCALE) : v[MAG_W-1:0];
      end
    endcase
  endfunction

  // largest k with 10^k <= mean^20
  function automatic logic [LEVEL_W-1:0] db_of_mean(logic [63:0] mean);
    logic [335:0] pw;
    logic [335:0] pten;
    int k;
    if (mean == 0) return '0;
    if (mean > FULL_SCALE) mean = FULL_SCALE;
    pw = 1;
    pten = 1;
    for (k = 0; k < 20; k++) pw = pw * mean;
    k = 0;
    while (k < 127 && pten * 10 <= pw) begin
      pten = pten * 10;
      k++;
    end
    return k[LEVEL_W-1:0];
  endfunction

  function automatic void predict_level(logic [SAMPLE_W-1:0] x);
    int unsigned len;
    level_rec_t rec;
    len = win_len_cfg;
    if (len == 0) len = 1;
    if (len > MAX_WINDOW) len = MAX_WINDOW;
    mag_sum += sample_magnitude(fmt_cfg, x);
    win_fill++;
    if (win_fill >= len) begin
      rec.db = db_of_mean(mag_sum / win_fill);
      rec.num = win_num;
      pending_levels.push_back(rec);
      win_num++;
      mag_sum = '0;
      win_fill = 0;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(fmt_t f);
    logic [31:0] mag;
    logic [31:0] r;
    int w;
    if ($urandom_range(4, 0) == 0) return $urandom();
    if (f == FMT_F32) begin
      r = $urandom();
      case ($urandom_range(9, 0))
        0: r[30:23] = 8'($urandom_range(255, 127));
        1: r[30:23] = 8'($urandom_range(99, 0));
        default: r[30:23] = 8'($urandom_range(126, 100));
      endcase
      return r;
    end
    w = (f == FMT_S16) ? 16 : (f == FMT_S24) ? 24 : 32;
    mag = $urandom() >> $urandom_range(31, 33 - w);
    r = $urandom_range(1, 0) ? -mag : mag;
    // bits above the sample width carry no meaning
    if (w < 32 && $urandom_range(1, 0)) r = (r & ((32'd1 << w) - 1)) | ($urandom() << w);
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] fmt_data(fmt_t f);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom());
    d[FMT_W-1:0] = f;
    return d;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == CFG_FORMAT) fmt_cfg = fmt_t'(val[FMT_W-1:0]);
    else win_len_cfg = val;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_pending.size() != 0 || samples.valid || pending_levels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample transfer: predict, then let the driver drop the item
  always @(posedge clk) begin
    if (!rst && samples.valid && samples.ready) begin
      predict_level(samples.sample_bits);
      sample_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : sample_drv
    logic nv;
    logic [SAMPLE_W-1:0] nb;
    nv = samples.valid;
    nb = samples.sample_bits;
    if (sample_taken) begin
      nv = 1'b0;
      sample_taken = 1'b0;
    end
    if (rst) begin
      nv = 1'b0;
    end else if (!nv) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (sample_pending.size() != 0) begin
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
          send_gap = $urandom_range(11, 0);
        end else begin
          nb = sample_pending.pop_front();
          nv = 1'b1;
        end
      end
    end
    samples.valid <= nv;
    samples.sample_bits <= nb;
  end

  always @(negedge clk) begin : level_ready_drv
    logic nr;
    if (level_hold_req != 0) begin
      level_hold_left = level_hold_req;
      level_hold_req = 0;
    end
    if (level_hold_left != 0) begin
      nr = 1'b0;
      level_hold_left--;
    end else if (recv_gap != 0) begin
      nr = 1'b0;
      recv_gap--;
    end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
      nr = 1'b0;
      recv_gap = $urandom_range(11, 0);
    end else begin
      nr = 1'b1;
    end
    levels.ready <= nr;
  end

  always @(posedge clk) begin : level_check
    level_rec_t want;
    if (!rst && levels.valid && levels.ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("level transfer with none outstanding", levels.level_db, -1);
      end else begin
        want = pending_levels.pop_front();
        if (levels.level_db !== want.db)
          report_mismatch("level_db", levels.level_db, want.db);
        if (levels.window_number !== want.num)
          report_mismatch("window_number", levels.window_number, want.num);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    fmt_t f;
    cfg.valid = 1'b0;
    cfg.index = CFG_FORMAT;
    cfg.data = '0;
    samples.valid = 1'b0;
    samples.sample_bits = '0;
    levels.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: 16-bit samples into a long window that stays open
    send_idle_pct = 2;
    recv_idle_pct = 20;
    repeat (40) sample_pending.push_back(random_sample(FMT_S16));
    wait_idle();

    // extremes of each format, one sample per window
    send_idle_pct = 30;
    recv_idle_pct = 30;
    write_reg(CFG_FORMAT, fmt_data(FMT_S16));
    write_reg(CFG_WINDOW, CFG_DATA_W'(1));
    sample_pending.push_back(32'h0000_0000);
    sample_pending.push_back(32'h0000_0001);
    sample_pending.push_back(32'h0000_7FFF);
    sample_pending.push_back(32'h0000_8000);
    sample_pending.push_back(32'h0000_FFFF);
    sample_pending.push_back(32'hFFFF_8000);
    sample_pending.push_back(32'h0000_000A);
    sample_pending.push_back(32'h0000_0009);
    wait_idle();
    write_reg(CFG_FORMAT, fmt_data(FMT_S24));
    sample_pending.push_back(32'h007F_FFFF);
    sample_pending.push_back(32'hAB80_0000);
    sample_pending.push_back(32'h0000_00FF);
    sample_pending.push_back(32'h0000_0100);
    wait_idle();
    write_reg(CFG_FORMAT, fmt_data(FMT_S32));
    sample_pending.push_back(32'h8000_0000);
    sample_pending.push_back(32'h7FFF_FFFF);
    sample_pending.push_back(32'hFFFF_FFFF);
    sample_pending.push_back(32'h0001_0000);
    wait_idle();
    // zero length acts as one
    write_reg(CFG_FORMAT, fmt_data(FMT_F32));
    write_reg(CFG_WINDOW, CFG_DATA_W'(0));
    sample_pending.push_back(32'h3F80_0000);
    sample_pending.push_back(32'hBF80_0000);
    sample_pending.push_back(32'h7F80_0000);
    sample_pending.push_back(32'h7FC0_0000);
    sample_pending.push_back(32'h0000_0001);
    sample_pending.push_back(32'h3F7F_FFFF);
    sample_pending.push_back(32'h3F00_0000);
    sample_pending.push_back(32'h3780_0000);
    sample_pending.push_back(32'h3800_0000);
    wait_idle();

    // length shortened below the count mid-window
    write_reg(CFG_FORMAT, fmt_data(FMT_S16));
    write_reg(CFG_WINDOW, CFG_DATA_W'(10));
    repeat (5) sample_pending.push_back(32'h0000_03E8);
    wait_idle();
    write_reg(CFG_WINDOW, CFG_DATA_W'(3));
    sample_pending.push_back(32'h0000_F000);
    wait_idle();
    // format switched mid-window
    write_reg(CFG_WINDOW, CFG_DATA_W'(4));
    sample_pending.push_back(32'h0000_4000);
    sample_pending.push_back(32'h0000_C123);
    wait_idle();
    write_reg(CFG_FORMAT, fmt_data(FMT_F32));
    sample_pending.push_back(32'h3F80_0000);
    sample_pending.push_back(32'h3E80_0000);
    wait_idle();

    // receiver holds off while short windows keep coming
    write_reg(CFG_FORMAT, fmt_data(FMT_S32));
    write_reg(CFG_WINDOW, CFG_DATA_W'(1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    level_hold_req = HOLD_CYCLES;
    repeat (60) sample_pending.push_back(random_sample(FMT_S32));
    wait_idle();

    // oversized lengths clamp and keep the window open, then a short one closes it
    send_idle_pct = 2;
    recv_idle_pct = 10;
    write_reg(CFG_FORMAT, fmt_data(FMT_S24));
    write_reg(CFG_WINDOW, {CFG_DATA_W{1'b1}});
    repeat (30) sample_pending.push_back(random_sample(FMT_S24));
    wait_idle();
    write_reg(CFG_WINDOW, CFG_DATA_W'(MAX_WINDOW + 1));
    repeat (30) sample_pending.push_back(random_sample(FMT_S24));
    wait_idle();
    write_reg(CFG_WINDOW, CFG_DATA_W'(5));
    sample_pending.push_back(random_sample(FMT_S24));
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(1, 0)) write_reg(CFG_FORMAT, fmt_data(fmt_t'($urandom_range(3, 0))));
      if ($urandom_range(2, 0) != 0) begin
        pick = $urandom_range(19, 0);
        if (pick == 0) len = 0;
        else if (pick < 4) len = $urandom_range(400, 65);
        else if (pick < 11) len = $urandom_range(64, 9);
        else len = $urandom_range(8, 1);
        write_reg(CFG_WINDOW, CFG_DATA_W'(len));
      end
      if (sent + 200 >= RANDOM_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        pick = $urandom_range(2, 0);
        send_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
        pick = $urandom_range(2, 0);
        recv_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
      end
      n = (win_len_cfg > 64) ? win_len_cfg + $urandom_range(win_len_cfg, 0)
                             : $urandom_range(120, 20);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      f = fmt_cfg;
      repeat (n) sample_pending.push_back(random_sample(f));
      sent += n;
      wait_idle();
    end

    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== pcm_window_level_db_top.f =====
+incdir+sv
sv/pcm_lvl_pkg.sv
sv/pcm_lvl_ifs.sv
sv/pcm_lvl_front.sv
sv/pcm_lvl_fifo.sv
sv/pcm_lvl_back.sv
sv/pcm_window_level_db_top.sv
sv/pcm_lvl_checker.sv
tb/sv/tb_top.sv
